FILE: hdl/sba_pkg.sv
// ----------------------------------------------------------------------------
// sba_pkg
// Shared types, constants and helpers of the sector bitmap allocator.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int SECTOR_W         = 11;
  localparam int TOTAL_W          = 11;
  localparam int BYTE_W           = 8;
  localparam int BIT_SEL_W        = 3;
  localparam int INDEX_IN_W       = 8;
  localparam int IN_DATA_W        = 32;
  localparam int OUT_DATA_W       = 16;
  localparam int DEF_BITMAP_BYTES = 200;
  localparam int DATA_START_BYTE  = 4;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd360;
  localparam logic [BYTE_W-1:0]  FIRST_BYTE_RESET = 8'h03;

  typedef enum logic [1:0] {
    CMD_ALLOC_DIR  = 2'd0,
    CMD_ALLOC_DATA = 2'd1,
    CMD_FREE       = 2'd2,
    CMD_LOAD       = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOD,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    status_t             status;
  } res_t;

  // Power-up contents: sectors 0 and 1 used, everything else free.
  function automatic logic [BYTE_W-1:0] reset_byte(input logic is_first);
    reset_byte = is_first ? FIRST_BYTE_RESET : '0;
  endfunction

  // Position of the lowest clear bit of a bitmap byte.
  function automatic logic [BIT_SEL_W-1:0] low_clear_bit(input logic [BYTE_W-1:0] b);
    logic [BIT_SEL_W-1:0] r;
    r = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (!b[i]) r = BIT_SEL_W'(i);
    end
    return r;
  endfunction

endpackage

FILE: hdl/sba_ram.sv
// ----------------------------------------------------------------------------
// sba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 200,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/sba_engine.sv
// ----------------------------------------------------------------------------
// sba_engine
// Command sequencer: bitmap RAM, per-byte valid bits, scan and read-modify-write.
// ----------------------------------------------------------------------------
module sba_engine import sba_pkg::*; #(
  parameter int BITMAP_BYTES = DEF_BITMAP_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [TOTAL_W-1:0]    total_sectors,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cmd_t                  in_command,
  input  logic [SECTOR_W-1:0]   in_sector,
  input  logic [INDEX_IN_W-1:0] in_bitmap_index,
  input  logic [BYTE_W-1:0]     in_bitmap_value,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_t                  res
);

  localparam int IDX_W  = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int SPAN_W = $clog2(BITMAP_BYTES + 1);
  localparam logic [8:0] BYTES9 = 9'(BITMAP_BYTES);
  localparam logic [8:0] START9 = 9'(DATA_START_BYTE);

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic [SPAN_W-1:0]     cnt_r, cnt_nxt;
  logic [SPAN_W-1:0]     span_r, span_nxt;
  logic [BIT_SEL_W-1:0]  bit_r, bit_nxt;
  res_t                  res_r, res_nxt;
  logic [BITMAP_BYTES-1:0] valid_r;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]     ram_wdata, ram_rdata;

  logic                  accept;
  logic [8:0]            span9;
  logic [SPAN_W-1:0]     span_c;
  logic [IDX_W-1:0]      start_c, free_idx, load_idx;
  logic                  alloc_empty, free_bad, load_bad;
  logic [BYTE_W-1:0]     cur_byte;
  logic [BIT_SEL_W-1:0]  scan_bit;
  logic                  scan_hit, scan_end;
  logic [SPAN_W-1:0]     pos_inc, cnt_inc;
  logic [IDX_W-1:0]      pos_wrap;

  sba_ram #(.WIDTH(BYTE_W), .DEPTH(BITMAP_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // decode
  assign accept   = in_valid && in_ready;
  assign span9    = ({1'b0, total_sectors[TOTAL_W-1:BIT_SEL_W]} > BYTES9) ? BYTES9
                    : {1'b0, total_sectors[TOTAL_W-1:BIT_SEL_W]};
  assign span_c   = SPAN_W'(span9);
  assign start_c  = (in_command == CMD_ALLOC_DATA && START9 < span9)
                    ? IDX_W'(DATA_START_BYTE) : '0;
  assign alloc_empty = (span9 == 9'd0);
  assign free_bad = (in_sector >= total_sectors) ||
                    ({1'b0, in_sector[SECTOR_W-1:BIT_SEL_W]} >= BYTES9);
  assign load_bad = ({1'b0, in_bitmap_index} >= BYTES9);
  assign free_idx = IDX_W'(in_sector[SECTOR_W-1:BIT_SEL_W]);
  assign load_idx = IDX_W'(in_bitmap_index);

  // byte under the scan/modify pointer; a never-written byte reads as its reset value
  assign cur_byte = valid_r[pos_r] ? ram_rdata : reset_byte(pos_r == '0);
  assign scan_bit = low_clear_bit(cur_byte);
  assign scan_hit = ~&cur_byte;
  assign cnt_inc  = cnt_r + 1'b1;
  assign scan_end = (cnt_inc == span_r);
  assign pos_inc  = SPAN_W'(pos_r) + 1'b1;
  assign pos_wrap = (pos_inc >= span_r) ? '0 : IDX_W'(pos_inc);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_ALLOC_DIR, CMD_ALLOC_DATA: state_nxt = alloc_empty ? S_RESP : S_SCAN;
            CMD_FREE:                      state_nxt = free_bad ? S_RESP : S_MOD;
            default:                       state_nxt = S_RESP;
          endcase
        end
      end
      S_SCAN:  if (scan_hit || scan_end) state_nxt = S_RESP;
      S_MOD:   state_nxt = S_RESP;
      S_RESP:  if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath registers
  always_comb begin
    pos_nxt  = pos_r;
    cnt_nxt  = cnt_r;
    span_nxt = span_r;
    bit_nxt  = bit_r;
    res_nxt  = res_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt = '{sector: '0, status: ST_OK};
          case (in_command)
            CMD_ALLOC_DIR, CMD_ALLOC_DATA: begin
              pos_nxt  = start_c;
              cnt_nxt  = '0;
              span_nxt = span_c;
              if (alloc_empty) res_nxt.status = ST_NOSPACE;
            end
            CMD_FREE: begin
              pos_nxt = free_idx;
              bit_nxt = in_sector[BIT_SEL_W-1:0];
              if (free_bad) res_nxt.status = ST_RANGE;
            end
            default: begin
              if (load_bad) res_nxt.status = ST_RANGE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          res_nxt = '{sector: SECTOR_W'({pos_r, scan_bit}), status: ST_OK};
        end else if (scan_end) begin
          res_nxt = '{sector: '0, status: ST_NOSPACE};
        end else begin
          pos_nxt = pos_wrap;
          cnt_nxt = cnt_inc;
        end
      end
      default: ;
    endcase
  end

  // outputs: handshake and RAM port
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    res_valid = (state_r == S_RESP);
    res       = res_r;
    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = cur_byte;
    ram_raddr = pos_r;
    case (state_r)
      S_IDLE: begin
        case (in_command)
          CMD_ALLOC_DIR, CMD_ALLOC_DATA: ram_raddr = start_c;
          CMD_FREE:                      ram_raddr = free_idx;
          default: begin
            ram_we    = accept && !load_bad;
            ram_waddr = load_idx;
            ram_wdata = in_bitmap_value;
          end
        endcase
      end
      S_SCAN: begin
        ram_raddr = pos_wrap;
        ram_we    = scan_hit;
        ram_wdata = cur_byte | (BYTE_W'(1) << scan_bit);
      end
      S_MOD: begin
        ram_we    = 1'b1;
        ram_wdata = cur_byte & ~(BYTE_W'(1) << bit_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) valid_r[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    cnt_r  <= cnt_nxt;
    span_r <= span_nxt;
    bit_r  <= bit_nxt;
    res_r  <= res_nxt;
  end

  // checks
  a_scan_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> cnt_r < span_r)
    else $error("scan count ran past span");

  a_scan_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> SPAN_W'(pos_r) < span_r)
    else $error("scan pointer outside span");

  a_hit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && ram_we) |=> state_r == S_RESP && res_r.status == ST_OK)
    else $error("allocation write did not end the scan");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status != ST_OK) |-> res.sector == '0)
    else $error("failed command reports a sector");

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> state_r == S_IDLE)
    else $error("sequencer not idle after reset");

endmodule

FILE: hdl/sector_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// sector_bitmap_allocator_core
// Disk sector allocation bitmap: allocate, free and load commands.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | word contents
//  --------+-----+----------------------+----------------------------------------
//  in_     | in  | tvalid/tready        | tuser: command; tdata: sector,
//          |     |                      |   bitmap_index, bitmap_value
//  out_    | out | tvalid/tready        | tuser: status; tdata: granted_sector
//  cfg_    | in  | valid/ready (ready=1)| data: total_sectors
//
// Allocate: a decode step, then one bitmap byte per cycle from the RAM
//   read port (up to min(total_sectors/8, BITMAP_BYTES) bytes), then a step to
//   present the result. Free: read, modify/write, result. Load: write, result.
// One command is in flight at a time; the next word is taken once the result
//   has moved into the output register, so the output can stall without
//   holding up the decode of the next command.
// Reset (rst_n, synchronous) clears the per-byte valid flags: bytes not yet
//   written read as the power-up bitmap. No clearing pass is needed.
// ----------------------------------------------------------------------------
module sector_bitmap_allocator_core import sba_pkg::*; #(
  parameter int BITMAP_BYTES = DEF_BITMAP_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [1:0] command
  input  logic [1:0]            in_tuser,
  // [10:0] sector, [18:11] bitmap_index, [26:19] bitmap_value, [31:27] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,

  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] status
  output logic [1:0]            out_tuser,
  // [10:0] granted_sector, [15:11] zero
  output logic [OUT_DATA_W-1:0] out_tdata,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TOTAL_W-1:0]    cfg_data
);

  logic [TOTAL_W-1:0] total_r;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_res_r, out_res_nxt;

  logic               res_valid, res_ready;
  res_t               res;

  // total_sectors register; to be written only while the core is idle (not enforced here)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOTAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      total_r <= cfg_data;
    end
  end

  sba_engine #(.BITMAP_BYTES(BITMAP_BYTES)) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .total_sectors   (total_r),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_command      (cmd_t'(in_tuser)),
    .in_sector       (in_tdata[10:0]),
    .in_bitmap_index (in_tdata[18:11]),
    .in_bitmap_value (in_tdata[26:19]),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

  // output register: the result word waits here for the sink
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = OUT_DATA_W'(out_res_r.sector);

endmodule

FILE: tb/sector_bitmap_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_bitmap_allocator_core_tb
// Self-checking bench for the sector bitmap allocator. A scoreboard keeps
// its own copy of the bitmap and of total_sectors and works out the reply
// to every accepted command. Replies are compared in order. Both stream
// sides idle at random. The run starts with directed corner cases and then
// runs random phases, each under its own total_sectors setting.
// ----------------------------------------------------------------------------
module sector_bitmap_allocator_core_tb import sba_pkg::*; ();

  // Scoreboard: shadow bitmap plus the queue of replies not yet seen.
  class bitmap_scoreboard;
    logic [BYTE_W-1:0]  usage [DEF_BITMAP_BYTES];
    logic [TOTAL_W-1:0] total;
    res_t               replies_due[$];
    int                 errors;

    function new();
      foreach (usage[i]) usage[i] = reset_byte(i == 0);
      total  = TOTAL_RESET;
      errors = 0;
    endfunction

    function void set_total(logic [TOTAL_W-1:0] t);
      total = t;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    // Apply one accepted command to the shadow bitmap, queue its reply.
    function void note_command(cmd_t cmd, logic [SECTOR_W-1:0] sec,
                               logic [INDEX_IN_W-1:0] idx, logic [BYTE_W-1:0] val);
      int   span;
      int   pos;
      int   bitpos;
      int   n;
      bit   found;
      res_t r;
      r.sector = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_ALLOC_DIR, CMD_ALLOC_DATA: begin
          span = total / 8;
          if (span > DEF_BITMAP_BYTES) span = DEF_BITMAP_BYTES;
          pos = (cmd == CMD_ALLOC_DATA) ? DATA_START_BYTE : 0;
          if (pos >= span) pos = 0;
          found = 1'b0;
          r.status = ST_NOSPACE;
          for (n = 0; n < span && !found; n++) begin
            if (usage[pos] != 8'hFF) begin
              bitpos = 0;
              for (int b = BYTE_W - 1; b >= 0; b--)
                if (!usage[pos][b]) bitpos = b;
              usage[pos][bitpos] = 1'b1;
              r.sector = SECTOR_W'(pos * 8 + bitpos);
              r.status = ST_OK;
              found    = 1'b1;
            end else begin
              pos++;
              if (pos >= span) pos = 0;
            end
          end
        end
        CMD_FREE: begin
          if (sec >= total || (sec >> 3) >= DEF_BITMAP_BYTES)
            r.status = ST_RANGE;
          else
            usage[sec >> 3][sec[2:0]] = 1'b0;
        end
        default: begin
          if (idx >= DEF_BITMAP_BYTES)
            r.status = ST_RANGE;
          else
            usage[idx] = val;
        end
      endcase
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [SECTOR_W-1:0] got_sector, logic [1:0] got_status);
      res_t want;
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected reply word: sector %0d status %0d", got_sector, got_status);
        return;
      end
      want = replies_due.pop_front();
      if (got_sector !== want.sector || got_status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display("reply mismatch: sector exp %0d got %0d, status exp %0d got %0d",
                   want.sector, got_sector, want.status, got_status);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [1:0]            in_tuser;   // [1:0] command
  logic [IN_DATA_W-1:0]  in_tdata;   // [10:0] sector, [18:11] index, [26:19] value
  logic                  out_tvalid;
  logic                  out_tready;
  logic [1:0]            out_tuser;  // [1:0] status
  logic [OUT_DATA_W-1:0] out_tdata;  // [10:0] granted_sector
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [TOTAL_W-1:0]    cfg_data;

  bitmap_scoreboard   sb;
  bit                 quiet;       // phase with no idling on either side
  int                 next_gap;    // idle cycles before the next input word
  logic [TOTAL_W-1:0] cur_total;

  sector_bitmap_allocator_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (every word a full scan).
  initial begin
    #(10_000_000);
    $display("[sector_bitmap_allocator_core] ERROR");
    $finish;
  end

  // Reply monitor: sampled at the edge, before any testbench update lands.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_reply(out_tdata[SECTOR_W-1:0], out_tuser);
  end

  // Reply sink: after each accepted reply, maybe hold tready low, the random
  // stall counted from the next reply's tvalid, so the stall lands on it.
  initial begin : reply_sink
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    out_tready <= 1'b1;
    forever begin
      do @(posedge clk); while (!(rst_n && out_tvalid && out_tready));
      stall = quiet ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_tready <= 1'b0;
        do @(posedge clk); while (!out_tvalid);
        repeat (stall - 1) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // Drive one command word. tvalid stays high into the next word when the
  // next gap is zero; otherwise it drops in the step of the handshake.
  task automatic send_word(cmd_t cmd, logic [SECTOR_W-1:0] sec,
                           logic [INDEX_IN_W-1:0] idx, logic [BYTE_W-1:0] val);
    repeat (next_gap) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'd0, val, idx, sec};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    sb.note_command(cmd, sec, idx, val);
    next_gap = quiet ? 0 : $urandom_range(0, 3);
    if (next_gap > 0) in_tvalid <= 1'b0;
  endtask

  // Release the input and wait for every reply plus a short settle.
  task automatic drain();
    if (next_gap == 0) in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // total_sectors is only changed with the block idle.
  task automatic set_total(logic [TOTAL_W-1:0] t);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= t;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sb.set_total(t);
    cur_total = t;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One random word, biased toward well-formed traffic inside the disk.
  task automatic send_random();
    int   pick;
    int   span;
    cmd_t cmd;
    logic [SECTOR_W-1:0]   sec;
    logic [INDEX_IN_W-1:0] idx;
    logic [BYTE_W-1:0]     val;
    span = cur_total / 8;
    if (span > DEF_BITMAP_BYTES) span = DEF_BITMAP_BYTES;
    pick = $urandom_range(0, 99);
    if (pick < 35)      cmd = CMD_ALLOC_DIR;
    else if (pick < 60) cmd = CMD_ALLOC_DATA;
    else if (pick < 80) cmd = CMD_FREE;
    else                cmd = CMD_LOAD;
    // sector: mostly on the disk, sometimes anywhere in the field
    if (cur_total == 0 || $urandom_range(0, 9) == 0)
      sec = SECTOR_W'($urandom_range(0, 2047));
    else
      sec = SECTOR_W'($urandom_range(0, cur_total - 1));
    // index: mostly inside the scanned bytes, sometimes anywhere
    if (span == 0 || $urandom_range(0, 7) == 0)
      idx = INDEX_IN_W'($urandom_range(0, 255));
    else
      idx = INDEX_IN_W'($urandom_range(0, span - 1));
    // full bytes push the scan toward wrap and no-space
    val = ($urandom_range(0, 1) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
    send_word(cmd, sec, idx, val);
  endtask

  initial begin : stimulus
    int t;
    sb        = new();
    quiet     = 1'b0;
    next_gap  = 1;
    cur_total = TOTAL_RESET;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= CMD_ALLOC_DIR;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset total of 360 sectors
    send_word(CMD_ALLOC_DIR,  11'd0,    8'd0,   8'h00);  // first free is sector 2
    send_word(CMD_ALLOC_DATA, 11'd0,    8'd0,   8'h00);  // data area starts at 32
    send_word(CMD_FREE,       11'd2,    8'd0,   8'h00);
    send_word(CMD_FREE,       11'd2,    8'd0,   8'h00);  // already free
    send_word(CMD_FREE,       11'd0,    8'd0,   8'h00);
    send_word(CMD_FREE,       11'd359,  8'd0,   8'h00);  // last sector on disk
    send_word(CMD_FREE,       11'd360,  8'd0,   8'h00);  // just past the end
    send_word(CMD_FREE,       11'd2047, 8'd0,   8'h00);
    send_word(CMD_LOAD,       11'd0,    8'd0,   8'hFF);
    send_word(CMD_LOAD,       11'd0,    8'd199, 8'hAA);  // last bitmap byte
    send_word(CMD_LOAD,       11'd0,    8'd200, 8'h55);  // index out of range
    send_word(CMD_LOAD,       11'd0,    8'd255, 8'h00);
    send_word(CMD_ALLOC_DIR,  11'd0,    8'd0,   8'h00);  // byte 0 full, moves on
    send_word(CMD_LOAD,       11'd0,    8'd0,   8'h00);

    // Two-byte disk: data start lies beyond the scan, then no space
    set_total(11'd16);
    send_word(CMD_LOAD,       11'd0,    8'd0,   8'hFF);
    send_word(CMD_LOAD,       11'd0,    8'd1,   8'hFF);
    send_word(CMD_ALLOC_DIR,  11'd0,    8'd0,   8'h00);
    send_word(CMD_ALLOC_DATA, 11'd0,    8'd0,   8'h00);
    send_word(CMD_FREE,       11'd15,   8'd0,   8'h00);
    send_word(CMD_FREE,       11'd16,   8'd0,   8'h00);
    send_word(CMD_ALLOC_DATA, 11'd0,    8'd0,   8'h00);  // starts at byte 0, gets 15

    // Empty scan range
    set_total(11'd7);
    send_word(CMD_ALLOC_DIR,  11'd0,    8'd0,   8'h00);
    set_total(11'd0);
    send_word(CMD_FREE,       11'd0,    8'd0,   8'h00);
    send_word(CMD_ALLOC_DATA, 11'd0,    8'd0,   8'h00);

    // Random phases, each with its own disk size
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       t = 360;
        1:       t = 0;
        2:       t = 8;
        3:       t = 39;
        4:       t = 40;
        5:       t = 64;
        6:       t = 96;
        7:       t = 1599;
        8:       t = 1600;
        9:       t = $urandom_range(8, 120);
        default: t = $urandom_range(0, 1600);
      endcase
      set_total(TOTAL_W'(t));
      quiet = ($urandom_range(0, 3) == 0);
      repeat (54) send_random();
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[sector_bitmap_allocator_core] OK");
    else
      $display("[sector_bitmap_allocator_core] ERROR");
    $finish;
  end

endmodule
